[src/cube_face_to_sphere_vertex_assert.svh]
// Assertion macros for the cube-to-sphere vertex block.
// The asserting scope must provide clk and rst_n.
`ifndef CUBE_FACE_TO_SPHERE_VERTEX_ASSERT_SVH
`define CUBE_FACE_TO_SPHERE_VERTEX_ASSERT_SVH

// Check a condition in the same cycle as its trigger.
`define CFSV_ASSERT_NOW(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error(msg);

// Check a condition in the cycle after its trigger.
`define CFSV_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

[src/cfsv_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package cfsv_pkg;

  // Cube faces: fixed axis and its sign
  typedef enum logic [2:0] {
    FACE_POS_X = 3'd0,
    FACE_NEG_X = 3'd1,
    FACE_POS_Y = 3'd2,
    FACE_NEG_Y = 3'd3,
    FACE_POS_Z = 3'd4,
    FACE_NEG_Z = 3'd5
  } face_t;

  localparam int ROT_STEPS = 30;
  localparam logic [30:0] HALF_PI_Q30    = 31'd1686629713;
  localparam logic [30:0] QUARTER_PI_Q30 = 31'd843314857;

  typedef logic [31:0] atan_tab_t [ROT_STEPS];

  // Arctangent of 2^-i in Q2.30, from the alternating series, rounded half up
  function automatic atan_tab_t build_atan_tab();
    atan_tab_t tab;
    longint sum;
    longint term;
    int e;
    tab[0] = 32'(QUARTER_PI_Q30);
    for (int i = 1; i < ROT_STEPS; i++) begin
      sum = 0;
      for (int k = 0; i * (2 * k + 1) <= 62; k++) begin
        e = i * (2 * k + 1);
        term = longint'((64'd1 << (62 - e)) / 64'(2 * k + 1));
        sum = ((k & 1) != 0) ? sum - term : sum + term;
      end
      tab[i] = 32'((64'(sum) + 64'd2147483648) >> 32);
    end
    return tab;
  endfunction

  localparam atan_tab_t ATAN_TAB = build_atan_tab();

  typedef struct packed {
    logic [2:0]  face;
    logic [16:0] coord_u;
    logic [16:0] coord_v;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
  } out_word_t;

endpackage

`default_nettype wire

[src/cfsv_stream_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface cfsv_stream_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[src/cube_face_to_sphere_vertex.sv]
`timescale 1ns / 1ps
`default_nettype none
// Equiangular cube-to-sphere vertex generator.
// in_ch (sink, word cfsv_pkg::in_word_t): face 0..5 and two face coordinates
//   in Q0.COORD_FRAC_BITS; coordinates above 1.0 are clamped, faces 6 and 7
//   give an all-zero vertex.
// out_ch (source, word cfsv_pkg::out_word_t): unit sphere point in signed
//   Q1.OUT_FRAC_BITS, saturated just below +1 and at -1. It also serves as the normal.
// Both channels move a word when valid and ready are high at a clock edge.
// Throughput: one word per cycle while the output is not stalled. Words pass the
//   input register, the 30 CORDIC stages, the product, square and sum registers,
//   the 32 square-root stages and the OUT_FRAC_BITS + 1 divider stages.
// Reset (rst_n low, synchronous) empties the pipeline and drops any words in
//   flight; no words are produced by it.
// When the receiver stalls, the output register holds its word and a skid
//   register takes one more; the pipeline then freezes in place and in_ch
//   drops ready until the skid register drains.
module cube_face_to_sphere_vertex #(
  parameter int COORD_FRAC_BITS = 16,
  parameter int OUT_FRAC_BITS   = 15
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  cfsv_stream_if.sink   in_ch,
  cfsv_stream_if.source out_ch
);
  import cfsv_pkg::*;

  localparam int MAG_W      = 31;
  localparam int LEN_W      = 32;
  localparam int SUM_W      = 64;
  localparam int SQRT_STEPS = 32;
  localparam int Q_W        = OUT_FRAC_BITS + 1;
  localparam int NUM_W      = LEN_W + OUT_FRAC_BITS;
  localparam int DIV_STEPS  = OUT_FRAC_BITS + 1;

  localparam logic [24:0]    COORD_ONE = 25'(1) << COORD_FRAC_BITS;
  localparam logic [32:0]    HALF_Q32  = 33'h080000000;
  localparam logic [Q_W-1:0] POS_LIM   =
    Q_W'((OUT_FRAC_BITS >= 15) ? 32767 : (1 << OUT_FRAC_BITS) - 1);
  localparam logic [Q_W-1:0] NEG_LIM   =
    Q_W'((OUT_FRAC_BITS >= 15) ? 32768 : (1 << OUT_FRAC_BITS));
  localparam logic [Q_W-1:0] Q_MAX     = Q_W'(1) << OUT_FRAC_BITS;

  typedef struct packed {
    logic        neg;
    logic [30:0] z;
  } ang_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } cv_t;

  typedef struct packed {
    logic [2:0] face;
    logic       neg_u;
    logic       neg_v;
    cv_t        u;
    cv_t        v;
  } rot_t;

  typedef struct packed {
    logic                  zero;
    logic [2:0]            neg;
    logic [2:0][MAG_W-1:0] mag;
  } vec_t;

  typedef struct packed {
    vec_t                    vec;
    logic [2:0][2*MAG_W-1:0] sq;
  } sqr_t;

  typedef struct packed {
    vec_t             vec;
    logic [SUM_W-1:0] n;
    logic [SUM_W-1:0] res;
  } rt_t;

  typedef struct packed {
    logic                  zero;
    logic [2:0]            neg;
    logic [LEN_W-1:0]      len;
    logic [2:0][NUM_W-1:0] rem;
    logic [2:0][Q_W-1:0]   q;
  } dv_t;

  // Clamp, recenter and scale a coordinate to an angle magnitude in Q2.30
  function automatic ang_t angle_of(input logic [16:0] c);
    logic [24:0] cc;
    logic [32:0] c32;
    logic [32:0] d;
    logic [62:0] prod;
    ang_t        a;
    cc    = (25'(c) > COORD_ONE) ? COORD_ONE : 25'(c);
    c32   = 33'(cc) << (32 - COORD_FRAC_BITS);
    a.neg = c32 < HALF_Q32;
    d     = a.neg ? (HALF_Q32 - c32) : (c32 - HALF_Q32);
    prod  = 63'(d[31:0]) * 63'(HALF_PI_Q30);
    a.z   = prod[62:32];
    return a;
  endfunction

  // One CORDIC rotation step with floor shifts
  function automatic cv_t rot_step(input cv_t s, input int sh, input logic [31:0] t);
    cv_t r;
    if (!s.z[31]) begin
      r.x = s.x - (s.y >>> sh);
      r.y = s.y + (s.x >>> sh);
      r.z = s.z - $signed(t);
    end else begin
      r.x = s.x + (s.y >>> sh);
      r.y = s.y - (s.x >>> sh);
      r.z = s.z + $signed(t);
    end
    return r;
  endfunction

  function automatic logic [MAG_W-1:0] mag_of(input logic signed [31:0] v);
    return MAG_W'(v[31] ? -v : v);
  endfunction

  // Scaled magnitude with +1 / -1 saturation and sign
  function automatic logic signed [15:0] to_field(input logic [Q_W-1:0] q, input logic neg);
    logic [Q_W-1:0] qc;
    logic [15:0]    f;
    if (neg) begin
      qc = (q > NEG_LIM) ? NEG_LIM : q;
      f  = 16'(32'd0 - 32'(qc));
    end else begin
      qc = (q > POS_LIM) ? POS_LIM : q;
      f  = 16'(qc);
    end
    return $signed(f);
  endfunction

  // Global advance: the pipeline moves while the skid register is empty
  logic      en;
  logic      skid_v_r;
  out_word_t skid_d_r;
  logic      out_v_r;
  out_word_t out_d_r;

  assign en          = !skid_v_r;
  assign in_ch.ready = en;

  // Input stage: angles and CORDIC start vectors
  rot_t rot_r   [ROT_STEPS+1];
  logic rot_v_r [ROT_STEPS+1];
  rot_t rot_in_nxt;
  ang_t ang_u, ang_v;

  always_comb begin
    ang_u               = angle_of(in_ch.data.coord_u);
    ang_v               = angle_of(in_ch.data.coord_v);
    rot_in_nxt.face     = in_ch.data.face;
    rot_in_nxt.neg_u    = ang_u.neg;
    rot_in_nxt.neg_v    = ang_v.neg;
    rot_in_nxt.u.x      = 32'sd1073741824;
    rot_in_nxt.u.y      = '0;
    rot_in_nxt.u.z      = $signed(32'(ang_u.z));
    rot_in_nxt.v.x      = 32'sd1073741824;
    rot_in_nxt.v.y      = '0;
    rot_in_nxt.v.z      = $signed(32'(ang_v.z));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_v_r[0] <= 1'b0;
    end else if (en) begin
      rot_v_r[0] <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot_r[0] <= rot_in_nxt;
    end
  end

  // CORDIC: one rotation step per stage for both angles
  for (genvar i = 0; i < ROT_STEPS; i++) begin : g_rot
    rot_t step_nxt;

    always_comb begin
      step_nxt   = rot_r[i];
      step_nxt.u = rot_step(rot_r[i].u, i, ATAN_TAB[i]);
      step_nxt.v = rot_step(rot_r[i].v, i, ATAN_TAB[i]);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rot_v_r[i+1] <= 1'b0;
      end else if (en) begin
        rot_v_r[i+1] <= rot_v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rot_r[i+1] <= step_nxt;
      end
    end
  end

  // Direction products and face mapping
  rot_t               rot_last;
  logic signed [31:0] sa, sb;
  logic [2*MAG_W-1:0] prod_a, prod_b, prod_c;
  logic [MAG_W-1:0]   m_a, m_b, m_c;
  logic               n_a, n_b, n_c;
  vec_t               pm_nxt;
  vec_t               pm_r;
  logic               pm_v_r;

  always_comb begin
    rot_last = rot_r[ROT_STEPS];
    sa       = rot_last.neg_u ? -rot_last.u.y : rot_last.u.y;
    sb       = rot_last.neg_v ? -rot_last.v.y : rot_last.v.y;
    prod_a   = (2*MAG_W)'(mag_of(sa)) * (2*MAG_W)'(mag_of(rot_last.v.x));
    prod_b   = (2*MAG_W)'(mag_of(rot_last.u.x)) * (2*MAG_W)'(mag_of(sb));
    prod_c   = (2*MAG_W)'(mag_of(rot_last.u.x)) * (2*MAG_W)'(mag_of(rot_last.v.x));
    m_a      = prod_a[2*MAG_W-1:MAG_W];
    m_b      = prod_b[2*MAG_W-1:MAG_W];
    m_c      = prod_c[2*MAG_W-1:MAG_W];
    n_a      = sa[31] != rot_last.v.x[31];
    n_b      = rot_last.u.x[31] != sb[31];
    n_c      = rot_last.u.x[31] != rot_last.v.x[31];
    pm_nxt   = '0;
    case (rot_last.face)
      FACE_POS_X, FACE_NEG_X: begin
        pm_nxt.mag = {m_b, m_a, m_c};
        pm_nxt.neg = {n_b, n_a, n_c ^ (rot_last.face == FACE_NEG_X)};
      end
      FACE_POS_Y, FACE_NEG_Y: begin
        pm_nxt.mag = {m_b, m_c, m_a};
        pm_nxt.neg = {n_b, n_c ^ (rot_last.face == FACE_NEG_Y), n_a};
      end
      FACE_POS_Z, FACE_NEG_Z: begin
        pm_nxt.mag = {m_c, m_b, m_a};
        pm_nxt.neg = {n_c ^ (rot_last.face == FACE_NEG_Z), n_b, n_a};
      end
      default: begin
        pm_nxt.zero = 1'b1;
      end
    endcase
  end

  // Squares of the components
  sqr_t sq_nxt;
  sqr_t sq_r;
  logic sq_v_r;

  always_comb begin
    sq_nxt.vec = pm_r;
    for (int k = 0; k < 3; k++) begin
      sq_nxt.sq[k] = (2*MAG_W)'(pm_r.mag[k]) * (2*MAG_W)'(pm_r.mag[k]);
    end
  end

  // Sum of squares seeds the square root
  rt_t rt_r   [SQRT_STEPS+1];
  logic rt_v_r [SQRT_STEPS+1];
  rt_t rt_in_nxt;

  always_comb begin
    rt_in_nxt.vec = sq_r.vec;
    rt_in_nxt.n   = SUM_W'(sq_r.sq[0]) + SUM_W'(sq_r.sq[1]) + SUM_W'(sq_r.sq[2]);
    rt_in_nxt.res = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pm_v_r    <= 1'b0;
      sq_v_r    <= 1'b0;
      rt_v_r[0] <= 1'b0;
    end else if (en) begin
      pm_v_r    <= rot_v_r[ROT_STEPS];
      sq_v_r    <= pm_v_r;
      rt_v_r[0] <= sq_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pm_r     <= pm_nxt;
      sq_r     <= sq_nxt;
      rt_r[0]  <= rt_in_nxt;
    end
  end

  // Integer square root: one result bit per stage
  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam logic [SUM_W-1:0] BIT_J = SUM_W'(1) << (62 - 2 * j);
    logic [SUM_W-1:0] trial;
    rt_t              step_nxt;

    always_comb begin
      step_nxt = rt_r[j];
      trial    = rt_r[j].res + BIT_J;
      if (rt_r[j].n >= trial) begin
        step_nxt.n   = rt_r[j].n - trial;
        step_nxt.res = (rt_r[j].res >> 1) + BIT_J;
      end else begin
        step_nxt.res = rt_r[j].res >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rt_v_r[j+1] <= 1'b0;
      end else if (en) begin
        rt_v_r[j+1] <= rt_v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rt_r[j+1] <= step_nxt;
      end
    end
  end

  // Divider setup: numerators with half the length added for rounding
  dv_t              dv_r   [DIV_STEPS+1];
  logic             dv_v_r [DIV_STEPS+1];
  dv_t              dv_in_nxt;
  logic [LEN_W-1:0] len;

  always_comb begin
    len            = rt_r[SQRT_STEPS].res[LEN_W-1:0];
    dv_in_nxt.zero = rt_r[SQRT_STEPS].vec.zero || (len == '0);
    dv_in_nxt.neg  = rt_r[SQRT_STEPS].vec.neg;
    dv_in_nxt.len  = len;
    dv_in_nxt.q    = '0;
    for (int k = 0; k < 3; k++) begin
      dv_in_nxt.rem[k] = (NUM_W'(rt_r[SQRT_STEPS].vec.mag[k]) << OUT_FRAC_BITS)
                       + NUM_W'(len >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (en) begin
      dv_v_r[0] <= rt_v_r[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r[0] <= dv_in_nxt;
    end
  end

  // Restoring division: one quotient bit per stage, most significant first
  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
    localparam int SH = OUT_FRAC_BITS - s;
    logic [NUM_W-1:0] dsr;
    dv_t              step_nxt;

    always_comb begin
      step_nxt = dv_r[s];
      dsr      = NUM_W'(dv_r[s].len) << SH;
      for (int k = 0; k < 3; k++) begin
        if (dv_r[s].rem[k] >= dsr) begin
          step_nxt.rem[k]   = dv_r[s].rem[k] - dsr;
          step_nxt.q[k][SH] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[s+1] <= 1'b0;
      end else if (en) begin
        dv_v_r[s+1] <= dv_v_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[s+1] <= step_nxt;
      end
    end
  end

  // Saturate and sign the quotients
  dv_t       dv_last;
  out_word_t tail_nxt;
  out_word_t tail_r;
  logic      tail_v_r;

  always_comb begin
    dv_last = dv_r[DIV_STEPS];
    if (dv_last.zero) begin
      tail_nxt = '0;
    end else begin
      tail_nxt.pos_x = to_field(dv_last.q[0], dv_last.neg[0]);
      tail_nxt.pos_y = to_field(dv_last.q[1], dv_last.neg[1]);
      tail_nxt.pos_z = to_field(dv_last.q[2], dv_last.neg[2]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tail_v_r <= 1'b0;
    end else if (en) begin
      tail_v_r <= dv_v_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tail_r <= tail_nxt;
    end
  end

  // Output register with skid: drain skid first, else take the tail word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_ch.ready || !out_v_r) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r  <= tail_v_r;
      end
    end else if (tail_v_r && !skid_v_r) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ch.ready || !out_v_r) begin
      out_d_r <= skid_v_r ? skid_d_r : tail_r;
    end else if (!skid_v_r) begin
      skid_d_r <= tail_r;
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_d_r;

`include "cube_face_to_sphere_vertex_assert.svh"

  `CFSV_ASSERT_NOW(a_skid_needs_out, skid_v_r, out_v_r,
    "skid register full while output register is empty")
  `CFSV_ASSERT_NEXT(a_stall_capture,
    out_v_r && !out_ch.ready && tail_v_r && !skid_v_r, skid_v_r,
    "stalled tail word not captured in skid register")
  `CFSV_ASSERT_NOW(a_quot_range, dv_v_r[DIV_STEPS] && !dv_r[DIV_STEPS].zero,
    (dv_r[DIV_STEPS].q[0] <= Q_MAX) && (dv_r[DIV_STEPS].q[1] <= Q_MAX)
      && (dv_r[DIV_STEPS].q[2] <= Q_MAX),
    "normalized component exceeds one")

endmodule

`default_nettype wire

[tb/cube_face_to_sphere_vertex_tb.sv]
`timescale 1ns / 1ps

module cube_face_to_sphere_vertex_tb;
  import cfsv_pkg::*;

  localparam int OUT_FB = 15;
  localparam int COORD_FB = 16;
  localparam int LATENCY = OUT_FB + 70;
  localparam int N_RANDOM = 1930;
  localparam int TAIL_ITEMS = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  cfsv_stream_if #(.word_t(in_word_t))  in_ch ();
  cfsv_stream_if #(.word_t(out_word_t)) out_ch ();

  cube_face_to_sphere_vertex #(
    .COORD_FRAC_BITS(COORD_FB),
    .OUT_FRAC_BITS(OUT_FB)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  in_word_t  pending_words[$];
  out_word_t vertex_expect[$];
  int        mismatches = 0;
  int        sent_count = 0;
  int        total_items = 0;
  bit        fill_done = 1'b0;
  bit        hold_long = 1'b0;
  bit        in_took = 1'b0;
  longint    atan_q30[ROT_STEPS];

  always #6 clk = ~clk;

  // Floor shift for signed values
  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  // Warp one coordinate and run the angle rotation; returns cos and signed sin
  task automatic warp_angle(input logic [16:0] c, output longint cosv, output longint sinv);
    longint unsigned cq, c32, d;
    longint x, y, z, dx, dy;
    bit neg;
    cq = c;
    if (cq > (64'd1 << COORD_FB)) cq = 64'd1 << COORD_FB;
    c32 = cq << (32 - COORD_FB);
    neg = c32 < 64'd2147483648;
    d = neg ? 64'd2147483648 - c32 : c32 - 64'd2147483648;
    z = longint'((d * 64'd1686629713) >> 32);
    x = 64'sd1 << 30;
    y = 0;
    for (int i = 0; i < ROT_STEPS; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_q30[i];
      end else begin
        x += dx; y -= dy; z += atan_q30[i];
      end
    end
    cosv = x;
    sinv = neg ? -y : y;
  endtask

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [15:0] scale_component(longint unsigned m, bit neg,
                                                  longint unsigned len);
    longint unsigned q;
    if (len == 0) return 16'd0;
    q = ((m << OUT_FB) + len / 2) / len;
    if (neg) begin
      if (q > (64'd1 << OUT_FB)) q = 64'd1 << OUT_FB;
      if (q > 32768) q = 32768;
      return 16'(64'd0 - q);
    end
    if (q > (64'd1 << OUT_FB) - 1) q = (64'd1 << OUT_FB) - 1;
    if (q > 32767) q = 32767;
    return 16'(q);
  endfunction

  function automatic longint unsigned abs_val(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  // Predict one sphere vertex
  task automatic predict_vertex(input in_word_t w, output out_word_t r);
    longint ca, sa, cb, sb;
    longint unsigned m[3], len;
    bit n[3];
    int ua, va, fa;
    bit fneg;
    r = '0;
    if (w.face > 3'd5) return;
    warp_angle(w.coord_u, ca, sa);
    warp_angle(w.coord_v, cb, sb);
    case (face_t'(w.face))
      FACE_POS_X, FACE_NEG_X: begin
        ua = 1; va = 2; fa = 0;
      end
      FACE_POS_Y, FACE_NEG_Y: begin
        ua = 0; va = 2; fa = 1;
      end
      default: begin
        ua = 0; va = 1; fa = 2;
      end
    endcase
    fneg = (face_t'(w.face) == FACE_NEG_X) || (face_t'(w.face) == FACE_NEG_Y) ||
           (face_t'(w.face) == FACE_NEG_Z);
    m[ua] = (abs_val(sa) * abs_val(cb)) >> 31;
    n[ua] = (sa < 0) != (cb < 0);
    m[va] = (abs_val(ca) * abs_val(sb)) >> 31;
    n[va] = (ca < 0) != (sb < 0);
    m[fa] = (abs_val(ca) * abs_val(cb)) >> 31;
    n[fa] = ((ca < 0) != (cb < 0)) != fneg;
    len = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
    r.pos_x = scale_component(m[0], n[0], len);
    r.pos_y = scale_component(m[1], n[1], len);
    r.pos_z = scale_component(m[2], n[2], len);
  endtask

  function automatic logic [16:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'($urandom_range(65537, 131071));
      3: return 17'd32768 + 17'($urandom_range(0, 4)) - 17'd2;
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic in_word_t make_word(int f, logic [16:0] u, logic [16:0] v);
    in_word_t w;
    w.face = 3'(f);
    w.coord_u = u;
    w.coord_v = v;
    return w;
  endfunction

  // Fill the stimulus queue: directed corners first, then random words
  initial begin
    logic [16:0] corners[5];
    for (int i = 0; i < ROT_STEPS; i++) atan_q30[i] = longint'(ATAN_TAB[i]);
    corners = '{17'd0, 17'd32768, 17'd65536, 17'd131071, 17'd1};
    for (int f = 0; f < 8; f++)
      pending_words.push_back(make_word(f, corners[f % 5], corners[(f + 2) % 5]));
    for (int k = 0; k < 6; k++)
      pending_words.push_back(make_word(k, corners[k % 3], corners[(k + 1) % 3 + 2 * (k & 1)]));
    pending_words.push_back(make_word(FACE_POS_Z, 17'd32768, 17'd32768));
    pending_words.push_back(make_word(FACE_NEG_Z, 17'd32768, 17'd32768));
    pending_words.push_back(make_word(FACE_POS_X, 17'd65536, 17'd65536));
    pending_words.push_back(make_word(FACE_NEG_Y, 17'd0, 17'd0));
    for (int k = 0; k < N_RANDOM; k++) begin
      if ($urandom_range(0, 19) == 0)
        pending_words.push_back(make_word($urandom_range(6, 7), rand_coord(), rand_coord()));
      else if ($urandom_range(0, 29) == 0)
        pending_words.push_back(in_word_t'($urandom));
      else
        pending_words.push_back(make_word($urandom_range(0, 5), rand_coord(), rand_coord()));
    end
    total_items = pending_words.size();
    fill_done = 1'b1;
  end

  // Driver: offer words at the falling edge, with bursts of idle cycles
  int src_gap = 0;
  in_word_t cur_word;
  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  always @(negedge clk) begin
    if (!rst_n || !fill_done) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_took) begin
      // hold the word until accepted
    end else begin
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_words.size() > 0 &&
                   (sent_count > total_items - TAIL_ITEMS || $urandom_range(0, 7) != 0)) begin
        cur_word = pending_words.pop_front();
        in_ch.data <= cur_word;
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
        if (pending_words.size() > 0) src_gap <= $urandom_range(1, 10) - 1;
      end
    end
  end

  // Record expectations for accepted words
  always @(posedge clk) begin
    out_word_t r;
    in_took <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      predict_vertex(in_ch.data, r);
      vertex_expect.push_back(r);
      sent_count <= sent_count + 1;
    end
  end

  // Receiver backpressure: one long hold-off, then random bursts
  int sink_gap = 0;
  int hold_cycles = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (!hold_long && sent_count >= 300 && hold_cycles == 0) begin
      hold_long <= 1'b1;
      hold_cycles <= 400;
      out_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= (hold_cycles == 1);
    end else if (sent_count > total_items - TAIL_ITEMS) begin
      out_ch.ready <= 1'b1;
    end else if (sink_gap > 0) begin
      sink_gap <= sink_gap - 1;
      out_ch.ready <= (sink_gap == 1);
    end else if ($urandom_range(0, 9) == 0) begin
      sink_gap <= $urandom_range(1, 10);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Monitor: compare each result word with the oldest expectation
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (vertex_expect.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected word %h", out_ch.data);
      end else begin
        want = vertex_expect.pop_front();
        if (out_ch.data.pos_x !== want.pos_x || out_ch.data.pos_y !== want.pos_y ||
            out_ch.data.pos_z !== want.pos_z) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected x=%0d y=%0d z=%0d, got x=%0d y=%0d z=%0d",
                     want.pos_x, want.pos_y, want.pos_z,
                     out_ch.data.pos_x, out_ch.data.pos_y, out_ch.data.pos_z);
        end
      end
    end
  end

  // Reset, then wait for the stream to drain
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    wait (fill_done);
    wait (sent_count == total_items);
    wait (vertex_expect.size() == 0);
    repeat (LATENCY + 20) @(posedge clk);
    if (mismatches == 0 && vertex_expect.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(12 * 200000);
    $display("Regression FAIL");
    $finish;
  end

endmodule
